// ----- rtl/lwis_pkg.sv -----
// Shared types and constants for the liveness watchdog interlock supervisor.
`default_nettype none

package lwis_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int LIMIT_WIDTH     = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OUTPUT_STALE_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PID_STALE_LIMIT    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMER_STALE_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_QUIET_WINDOW_TICKS = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DROPOUT_TICKS      = 3'd4;

    // Machine modes
    localparam logic [1:0] MODE_AWAIT_CONTACTOR = 2'd0;
    localparam logic [1:0] MODE_DISARMED        = 2'd1;
    localparam logic [1:0] MODE_ARMED           = 2'd2;

    // Reset values of the configuration registers
    localparam logic [LIMIT_WIDTH-1:0] RST_OUTPUT_STALE_LIMIT = 8'd2;
    localparam logic [LIMIT_WIDTH-1:0] RST_PID_STALE_LIMIT    = 8'd8;
    localparam logic [LIMIT_WIDTH-1:0] RST_TIMER_STALE_LIMIT  = 8'd8;
    localparam logic [LIMIT_WIDTH-1:0] RST_QUIET_WINDOW_TICKS = 8'd10;
    localparam logic [LIMIT_WIDTH-1:0] RST_DROPOUT_TICKS      = 8'd5;

    // Control from the top level to each stale tracker
    typedef struct packed {
        logic capture;  // load the last-seen value only
        logic update;   // track: load last-seen value and stale count
    } track_ctl_t;

    typedef struct packed {
        logic health_pulse;
        logic onchip_feed;
        logic fault_output_stale;
        logic fault_pid_stale;
        logic fault_timer_stall;
        logic fault_weld;
        logic interlock_ready;
        logic confirm_request;
        logic lost_request;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/lwis_stale_track.sv -----
// Stale counter for one liveness sequence: last-seen value and saturating count.
`default_nettype none

module lwis_stale_track #(
    parameter int CMP_WIDTH   = 32,
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire lwis_pkg::track_ctl_t               ctl,
    input  wire logic [CMP_WIDTH-1:0]               cur_seq,
    input  wire logic [lwis_pkg::LIMIT_WIDTH-1:0]   limit,
    output logic                                    stale
);

    localparam int CMP_CNT_WIDTH =
        (COUNT_WIDTH > lwis_pkg::LIMIT_WIDTH) ? COUNT_WIDTH : lwis_pkg::LIMIT_WIDTH;

    logic [CMP_WIDTH-1:0]   last_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    always_comb begin
        if (cur_seq != last_reg) begin
            count_next = '0;
        end else if (count_reg == {COUNT_WIDTH{1'b1}}) begin
            count_next = count_reg;
        end else begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
    end

    assign stale = CMP_CNT_WIDTH'(count_next) > CMP_CNT_WIDTH'(limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (ctl.capture || ctl.update) begin
                last_reg <= cur_seq;
            end
            if (ctl.update) begin
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/liveness_watchdog_interlock_supervisor.sv -----
// Top level of the liveness watchdog and contactor interlock supervisor.
//
// Usage: each transfer on the s_ channel is one supervision tick carrying three
// liveness sequence samples, the contactor feedback, the machine mode and a
// fault-present flag. Each tick produces exactly one result transfer on the m_
// channel with the health pulse, watchdog feed, fault and request flags.
// The result register holds the outcome of an accepted tick from the next cycle.
// One tick per cycle is sustained while the receiver takes each result; the result
// register is the only stage, and a new tick is taken whenever that register is empty
// or drained in the same cycle. When the receiver stalls, the result holds and s_ready
// drops until it is taken.
// Configuration goes through the cfg_ channel (always ready); write it only
// while no tick is in flight. Indexes beyond the register list are ignored.
// Reset (aresetn low, synchronous) restores the register defaults, empties the
// result register and restarts the startup quiet window, during which only the
// weld fault and the interlock-ready request can be raised.
`default_nettype none

module liveness_watchdog_interlock_supervisor #(
    parameter int SEQ_WIDTH   = 32,
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,

    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [lwis_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [lwis_pkg::LIMIT_WIDTH-1:0]         cfg_data,

    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic [31:0]                              s_pid_seq,
    input  wire logic [31:0]                              s_output_seq,
    input  wire logic [31:0]                              s_timer_seq,
    input  wire logic                                     s_contactor_closed,
    input  wire logic [1:0]                               s_supervised_mode,
    input  wire logic                                     s_fault_present,

    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic                                          m_health_pulse,
    output logic                                          m_onchip_feed,
    output logic                                          m_fault_output_stale,
    output logic                                          m_fault_pid_stale,
    output logic                                          m_fault_timer_stall,
    output logic                                          m_fault_weld,
    output logic                                          m_interlock_ready,
    output logic                                          m_confirm_request,
    output logic                                          m_lost_request
);

    localparam int LW        = lwis_pkg::LIMIT_WIDTH;
    localparam int CMP_WIDTH = (SEQ_WIDTH < 32) ? SEQ_WIDTH : 32;
    localparam int CMP_CNT_WIDTH = (COUNT_WIDTH > LW) ? COUNT_WIDTH : LW;

    // Configuration registers
    logic [LW-1:0] output_limit_reg;
    logic [LW-1:0] pid_limit_reg;
    logic [LW-1:0] timer_limit_reg;
    logic [LW-1:0] quiet_ticks_reg;
    logic [LW-1:0] dropout_ticks_reg;

    // Supervision state
    logic                   quiet_reg;
    logic                   quiet_next;
    logic [LW-1:0]          quiet_count_reg;
    logic [LW-1:0]          quiet_count_next;
    logic [COUNT_WIDTH-1:0] dropout_count_reg;
    logic [COUNT_WIDTH-1:0] dropout_count_next;

    logic                   m_valid_reg;
    lwis_pkg::result_t      res_reg;
    lwis_pkg::result_t      res_next;

    logic                   accept;
    lwis_pkg::track_ctl_t   track_ctl;
    logic                   quiet_done;
    logic                   stale_out;
    logic                   stale_pid;
    logic                   stale_tmr;
    logic                   alive;
    logic                   healthy;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_limit_reg  <= lwis_pkg::RST_OUTPUT_STALE_LIMIT;
            pid_limit_reg     <= lwis_pkg::RST_PID_STALE_LIMIT;
            timer_limit_reg   <= lwis_pkg::RST_TIMER_STALE_LIMIT;
            quiet_ticks_reg   <= lwis_pkg::RST_QUIET_WINDOW_TICKS;
            dropout_ticks_reg <= lwis_pkg::RST_DROPOUT_TICKS;
        end else if (cfg_valid) begin
            case (cfg_index)
                lwis_pkg::CFG_OUTPUT_STALE_LIMIT: output_limit_reg  <= cfg_data;
                lwis_pkg::CFG_PID_STALE_LIMIT:    pid_limit_reg     <= cfg_data;
                lwis_pkg::CFG_TIMER_STALE_LIMIT:  timer_limit_reg   <= cfg_data;
                lwis_pkg::CFG_QUIET_WINDOW_TICKS: quiet_ticks_reg   <= cfg_data;
                lwis_pkg::CFG_DROPOUT_TICKS:      dropout_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Quiet window: counts open ticks; a closed contactor ends it with a weld fault
    always_comb begin
        quiet_count_next = quiet_count_reg;
        if (!s_contactor_closed && quiet_count_reg != {LW{1'b1}}) begin
            quiet_count_next = quiet_count_reg + LW'(1);
        end
    end

    assign quiet_done = s_contactor_closed || (quiet_count_next >= quiet_ticks_reg);

    assign track_ctl.capture = accept && quiet_reg && quiet_done;
    assign track_ctl.update  = accept && !quiet_reg;

    lwis_stale_track #(
        .CMP_WIDTH   (CMP_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_track_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (track_ctl),
        .cur_seq (s_output_seq[CMP_WIDTH-1:0]),
        .limit   (output_limit_reg),
        .stale   (stale_out)
    );

    lwis_stale_track #(
        .CMP_WIDTH   (CMP_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_track_pid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (track_ctl),
        .cur_seq (s_pid_seq[CMP_WIDTH-1:0]),
        .limit   (pid_limit_reg),
        .stale   (stale_pid)
    );

    lwis_stale_track #(
        .CMP_WIDTH   (CMP_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_track_tmr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (track_ctl),
        .cur_seq (s_timer_seq[CMP_WIDTH-1:0]),
        .limit   (timer_limit_reg),
        .stale   (stale_tmr)
    );

    assign alive   = !stale_out && !stale_pid && !stale_tmr;
    assign healthy = alive && !s_fault_present;

    always_comb begin
        res_next           = '0;
        quiet_next         = quiet_reg;
        dropout_count_next = dropout_count_reg;
        if (quiet_reg) begin
            res_next.fault_weld      = s_contactor_closed;
            res_next.interlock_ready = !s_contactor_closed && quiet_done;
            quiet_next               = !quiet_done;
        end else begin
            res_next.onchip_feed        = alive;
            res_next.health_pulse       = healthy;
            res_next.fault_output_stale = stale_out;
            res_next.fault_pid_stale    = stale_pid;
            res_next.fault_timer_stall  = stale_tmr;
            if (healthy) begin
                dropout_count_next = '0;
                if (s_supervised_mode == lwis_pkg::MODE_AWAIT_CONTACTOR) begin
                    res_next.confirm_request = s_contactor_closed;
                end else begin
                    res_next.lost_request = !s_contactor_closed &&
                        (s_supervised_mode == lwis_pkg::MODE_DISARMED ||
                         s_supervised_mode == lwis_pkg::MODE_ARMED);
                end
            end else if (CMP_CNT_WIDTH'(dropout_count_reg) <=
                         CMP_CNT_WIDTH'(dropout_ticks_reg)) begin
                if (dropout_count_reg != {COUNT_WIDTH{1'b1}}) begin
                    dropout_count_next = dropout_count_reg + COUNT_WIDTH'(1);
                end
            end else begin
                // past the drop-out deadline: contactor still closed means weld
                res_next.fault_weld = s_contactor_closed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quiet_reg         <= 1'b1;
            quiet_count_reg   <= '0;
            dropout_count_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                quiet_reg         <= quiet_next;
                dropout_count_reg <= dropout_count_next;
                if (quiet_reg) begin
                    quiet_count_reg <= quiet_count_next;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_health_pulse       = res_reg.health_pulse;
    assign m_onchip_feed        = res_reg.onchip_feed;
    assign m_fault_output_stale = res_reg.fault_output_stale;
    assign m_fault_pid_stale    = res_reg.fault_pid_stale;
    assign m_fault_timer_stall  = res_reg.fault_timer_stall;
    assign m_fault_weld         = res_reg.fault_weld;
    assign m_interlock_ready    = res_reg.interlock_ready;
    assign m_confirm_request    = res_reg.confirm_request;
    assign m_lost_request       = res_reg.lost_request;

    // Once the quiet window ends it never restarts without reset
    a_quiet_no_reentry: assert property (@(posedge aclk) disable iff (!aresetn)
        !quiet_reg |=> !quiet_reg)
        else $error("quiet window re-entered");

    // The drop-out counter only runs after the quiet window
    a_dropout_idle_in_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        quiet_reg |-> dropout_count_reg == '0)
        else $error("drop-out counter moved during quiet window");

    // A health pulse is only sent when the watchdog is fed
    a_pulse_implies_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.health_pulse |-> res_reg.onchip_feed)
        else $error("health pulse without watchdog feed");

    // A stale fault always withholds the watchdog feed
    a_stale_blocks_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (res_reg.fault_output_stale || res_reg.fault_pid_stale ||
                        res_reg.fault_timer_stall) |-> !res_reg.onchip_feed)
        else $error("watchdog fed with a stale source");

    // Confirm and lost requests are exclusive and need the health pulse
    a_requests_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (res_reg.confirm_request || res_reg.lost_request) |->
            res_reg.health_pulse && !(res_reg.confirm_request && res_reg.lost_request))
        else $error("contactor request without health or both requests");

endmodule

`default_nettype wire
